// ===== rtl/core/lars_pkg.sv =====
package lars_pkg;

	// Fixed row width of the data path.
	localparam int ROW_W = 64;
	// Default number of column cells.
	localparam int MAX_COLUMNS_DEF = 64;
	// Width of the column-count register and its reset value.
	localparam int WIDTH_W = 7;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;
	// Result queue depth and its pointer and counter widths.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
	// Neighbor counts that decide the next state.
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT = 4'd2;

	typedef logic [WIDTH_W-1:0] width_t;

	// Input word: one grid row and the end-of-grid flag.
	typedef struct packed {
		logic [ROW_W-1:0] row_cells;
		logic last_row;
	} in_word_t;

	// Output word: one next-generation row and the end-of-grid flag.
	typedef struct packed {
		logic [ROW_W-1:0] next_row;
		logic grid_done;
	} out_word_t;

	// Row-store control shared by all column cells.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Column bits that a cell hands to its neighbors, already masked by column use.
	typedef struct packed {
		logic upper;
		logic centre;
		logic row;
	} nbr_t;

	// Queue write request: one or two words in a cycle.
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// Next state of one cell from its own state and its eight neighbors.
	function automatic logic next_state(input logic alive, input logic [7:0] nbrs);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < 8; k++) begin
			n = n + 4'(nbrs[k]);
		end
		return (n == BIRTH_COUNT) || (alive && (n == KEEP_COUNT));
	endfunction

endpackage

// ===== rtl/core/lars_cell.sv =====
module lars_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lars_pkg::cell_ctrl_t ctrl,
	input  logic                use_col,
	input  logic                row_bit,
	input  lars_pkg::nbr_t      left,
	input  lars_pkg::nbr_t      right,
	output lars_pkg::nbr_t      own,
	output logic                res_mid,
	output logic                res_last
);

	logic upper_q;
	logic centre_q;
	logic up_m;
	logic ce_m;
	logic rw_m;

	// Columns beyond the width in use read as dead.
	assign up_m = upper_q & use_col;
	assign ce_m = centre_q & use_col;
	assign rw_m = row_bit & use_col;

	assign own.upper  = up_m;
	assign own.centre = ce_m;
	assign own.row    = rw_m;

	// Centre row's next generation, with the incoming row below it.
	assign res_mid = use_col & lars_pkg::next_state(ce_m,
		{left.upper, up_m, right.upper, left.centre, right.centre,
		 left.row, rw_m, right.row});

	// Incoming row's next generation as the last row, nothing below it.
	assign res_last = use_col & lars_pkg::next_state(rw_m,
		{left.centre, ce_m, right.centre, left.row, right.row, 3'b000});

	// Two-row store for this column: shift down on a row, clear at the end of a grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= 1'b0;
			centre_q <= 1'b0;
		end else if (ctrl.clear) begin
			upper_q  <= 1'b0;
			centre_q <= 1'b0;
		end else if (ctrl.shift) begin
			upper_q  <= centre_q;
			centre_q <= rw_m;
		end
	end

endmodule

// ===== rtl/core/lars_outq.sv =====
module lars_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lars_pkg::push_t      push,
	input  lars_pkg::out_word_t  word0,
	input  lars_pkg::out_word_t  word1,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lars_pkg::out_word_t  out_data
);

	localparam int DEPTH = lars_pkg::Q_DEPTH;
	localparam int PTR_W = lars_pkg::Q_PTR_W;
	localparam int CNT_W = lars_pkg::Q_CNT_W;

	lars_pkg::out_word_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] push_n;
	logic pop;

	// Room for the two words that one input row can produce.
	assign room      = (count_q <= CNT_W'(DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid & out_ready;
	assign push_n    = CNT_W'(push.first) + CNT_W'(push.second);

	// Word storage, written at the write pointer and the one after it.
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= word0;
		end
		if (push.second) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= word1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + push_n - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/life_automaton_row_step_top.sv =====
// Channel   Direction  Handshake              Word
// in        input      in_valid / in_ready    in_data   (row_cells, last_row)
// out       output     out_valid / out_ready  out_data  (next_row, grid_done)
// cfg       input      cfg_we                 cfg_wdata (grid_width)
//
// One row is accepted per cycle while in_ready is high; its results are queued at the
// same edge, and the first is shown on the next cycle if the queue was empty.
// A row flagged last yields two words when a centre row is held, else one word.
// The rate is set by the four-word result queue: in_ready is high while at least
// two words are free, and the column cells themselves take a row every cycle.
// Reset clears the stored rows, the queue and sets the width to 64; no clearing pass.
module life_automaton_row_step_top #(
	parameter int MAX_COLUMNS = lars_pkg::MAX_COLUMNS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lars_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lars_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  lars_pkg::width_t    cfg_wdata
);

	localparam int ROW_W = lars_pkg::ROW_W;

	lars_pkg::width_t    width_q;
	logic                held_q;
	logic                acc;
	lars_pkg::cell_ctrl_t ctrl;
	lars_pkg::push_t     push;
	lars_pkg::out_word_t word0;
	lars_pkg::out_word_t word1;
	lars_pkg::nbr_t      nb [MAX_COLUMNS+2];
	logic [ROW_W-1:0]    res_mid;
	logic [ROW_W-1:0]    res_last;
	logic [ROW_W-1:0]    use_col;

	// Column-count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= lars_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	// Whether a centre row is held for the current grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (acc) begin
			held_q <= !in_data.last_row;
		end
	end

	assign acc        = in_valid & in_ready;
	assign ctrl.shift = acc & !in_data.last_row;
	assign ctrl.clear = acc & in_data.last_row;

	// Edges of the grid are dead.
	assign nb[0]             = '0;
	assign nb[MAX_COLUMNS+1] = '0;

	// One cell per column in the chain; columns past the cell count stay dead.
	for (genvar j = 0; j < ROW_W; j++) begin : g_col
		assign use_col[j] = (width_q > lars_pkg::width_t'(j));
		if (j < MAX_COLUMNS) begin : g_cell
			lars_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.use_col  (use_col[j]),
				.row_bit  (in_data.row_cells[j]),
				.left     (nb[j]),
				.right    (nb[j+2]),
				.own      (nb[j+1]),
				.res_mid  (res_mid[j]),
				.res_last (res_last[j])
			);
		end else begin : g_dead
			assign res_mid[j]  = 1'b0;
			assign res_last[j] = 1'b0;
		end
	end

	// A held grid yields the centre row's result, then on the last row the last row's.
	// Without a held row the stored rows are dead, so the last-row result is the answer.
	assign push.first  = acc & (held_q | in_data.last_row);
	assign push.second = acc & held_q & in_data.last_row;
	assign word0.next_row  = held_q ? res_mid : res_last;
	assign word0.grid_done = !held_q;
	assign word1.next_row  = res_last;
	assign word1.grid_done = 1'b1;

	lars_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.word0     (word0),
		.word1     (word1),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/lars_checker.sv =====
module lars_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input lars_pkg::in_word_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input lars_pkg::out_word_t out_data,
	input logic                cfg_we,
	input lars_pkg::width_t    cfg_wdata
);

	localparam int ROW_W = lars_pkg::ROW_W;

	lars_pkg::width_t width_q;
	logic [ROW_W-1:0] unused_mask;

	// Shadow of the column-count register, seen from the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= lars_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	// Columns at or beyond the width in use.
	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			unused_mask[j] = !(width_q > lars_pkg::width_t'(j));
		end
	end

	// A stalled output word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// A stalled output word keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output word changed while stalled");

	// Columns outside the grid are always dead in the result.
	a_dead_cols: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.next_row & unused_mask) == '0))
		else $error("live cell beyond the width in use");

	// The last row of a grid always leaves a word to deliver.
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_row |=> out_valid)
		else $error("no result after the last row");

endmodule

bind life_automaton_row_step_top lars_checker u_lars_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata)
);
